@@ design/uftq_pkg.sv @@
// Shared types and constants for the multichannel under-temperature fault qualifier.
package uftq_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int THR_W          = 16;
    localparam int TIME_W         = 8;
    localparam int CNT_W          = 6;
    localparam int CH_W           = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DEF_MAX_CHANNELS = 32;

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_SETTING   = 2'd1,
        ST_SET       = 2'd2,
        ST_RELEASING = 2'd3
    } t_fault_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_THR  = 3'd0,
        REG_SET_TIME = 3'd1,
        REG_REL_THR  = 3'd2,
        REG_REL_TIME = 3'd3,
        REG_CHAN_CNT = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [THR_W-1:0]  set_thr;
        logic [TIME_W-1:0] set_time;
        logic [THR_W-1:0]  rel_thr;
        logic [TIME_W-1:0] rel_time;
        logic [CNT_W-1:0]  chan_cnt;
    } t_cfg;

    typedef struct packed {
        t_fault_state      st;
        logic [TIME_W-1:0] set_cnt;
        logic [TIME_W-1:0] rel_cnt;
    } t_chan_rec;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            set_event;
        logic            release_event;
        t_fault_state    fault_state;
        logic            scan_done;
    } t_result;

endpackage

@@ design/uftq_if.sv @@
// Handshake channel interfaces: sample input, result output, register writes.
interface uftq_smp_if import uftq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface uftq_res_if import uftq_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic            set_event;
    logic            release_event;
    logic [1:0]      fault_state;
    logic            scan_done;

    modport source (output valid, output channel, output set_event, output release_event,
                    output fault_state, output scan_done, input ready);
    modport sink   (input valid, input channel, input set_event, input release_event,
                    input fault_state, input scan_done, output ready);
endinterface

interface uftq_cfg_if import uftq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/uftq_chan_update.sv @@
// Per-channel fault state update: set phase, then release phase, on one sample.
module uftq_chan_update import uftq_pkg::*; (
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    input  t_chan_rec           i_rec,
    output t_chan_rec           o_rec,
    output logic                o_set_event,
    output logic                o_release_event
);

    logic              set_q;
    logic              rel_q;
    logic [TIME_W-1:0] set_inc;
    logic [TIME_W-1:0] rel_inc;

    assign set_q   = (i_sample > i_cfg.set_thr) && (i_cfg.set_time != '0);
    assign rel_q   = (i_sample < i_cfg.rel_thr) && (i_cfg.rel_time != '0);
    assign set_inc = i_rec.set_cnt + TIME_W'(1);
    assign rel_inc = i_rec.rel_cnt + TIME_W'(1);

    always_comb begin
        t_chan_rec rec;
        rec             = i_rec;
        o_set_event     = 1'b0;
        o_release_event = 1'b0;

        // set phase
        if (set_q) begin
            if (rec.st == ST_NORMAL) begin
                rec.st      = ST_SETTING;
                rec.set_cnt = TIME_W'(1);
            end else if (rec.st == ST_SETTING) begin
                rec.set_cnt = set_inc;
                if (set_inc >= i_cfg.set_time) begin
                    rec.st      = ST_SET;
                    rec.set_cnt = '0;
                    o_set_event = 1'b1;
                end
            end
        end else if (rec.st == ST_SETTING) begin
            rec.st = ST_NORMAL;
        end

        // release phase sees what the set phase left
        if (rel_q) begin
            if (rec.st == ST_SET) begin
                rec.st      = ST_RELEASING;
                rec.rel_cnt = TIME_W'(1);
            end else if (rec.st == ST_RELEASING) begin
                rec.rel_cnt = rel_inc;
                if (rel_inc >= i_cfg.rel_time) begin
                    rec.st          = ST_NORMAL;
                    rec.rel_cnt     = '0;
                    o_release_event = 1'b1;
                end
            end
        end else if (rec.st == ST_RELEASING) begin
            rec.st = ST_SET;
        end

        o_rec = rec;
    end

endmodule

@@ design/uftq_out_skid.sv @@
// Two-entry result buffer: output register plus skid register.
module uftq_out_skid import uftq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  t_result i_in_res,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_result o_out_res,
    input  logic    i_out_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_res;
    t_result r_skid_res;
    logic    drain;

    assign drain       = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_in_fire;
            end
        end else if (i_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            if (r_skid_valid) begin
                r_out_res <= r_skid_res;
            end else if (i_in_fire) begin
                r_out_res <= i_in_res;
            end
        end else if (i_in_fire) begin
            r_skid_res <= i_in_res;
        end
    end

endmodule

@@ design/multichannel_undertemp_fault_qualifier.sv @@
// Top level of the multichannel under-temperature fault qualifier.
//
//  port    dir  beat carries                                          note
//  i_smp   in   sample                                                one per scanned channel
//  o_res   out  channel, set/release event, fault_state, scan_done    one per sample
//  i_cfg   in   index, data                                           always ready
//
// One sample beat per cycle, sustained while i_smp.ready stays high. A sample is
// accepted while ready is high; its per-channel record is read, updated and written back
// at that edge and the result lands in the output register, or in the skid register.
// Reset clears the scan index and every channel record (normal, counters zero) at once.
// A stalled output holds one result and parks a second in the skid register; only then
// does i_smp.ready drop.
module multichannel_undertemp_fault_qualifier import uftq_pkg::*; #(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uftq_smp_if.sink  i_smp,
    uftq_res_if.source o_res,
    uftq_cfg_if.sink  i_cfg
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NXT_W = IDX_W + 1;
    localparam int CMP_W = (NXT_W > CNT_W) ? NXT_W : CNT_W;

    // configuration registers
    t_cfg r_cfg;

    // scan position and per-channel records
    logic [IDX_W-1:0] r_scan_idx;
    t_chan_rec        r_chan [MAX_CHANNELS];

    logic             in_ready;
    logic             in_fire;
    t_chan_rec        cur_rec;
    t_chan_rec        n_rec;
    logic             set_ev;
    logic             rel_ev;
    logic [NXT_W-1:0] idx_next;
    logic             wrap;
    logic [IDX_W-1:0] n_scan_idx;
    logic [CH_W+IDX_W-1:0] ch_ext;
    t_result          res;
    t_result          out_res;
    logic             out_valid;

    // register writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_thr  <= '0;
            r_cfg.set_time <= '0;
            r_cfg.rel_thr  <= '0;
            r_cfg.rel_time <= '0;
            r_cfg.chan_cnt <= CNT_W'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_SET_THR:  r_cfg.set_thr  <= i_cfg.data[THR_W-1:0];
                REG_SET_TIME: r_cfg.set_time <= i_cfg.data[TIME_W-1:0];
                REG_REL_THR:  r_cfg.rel_thr  <= i_cfg.data[THR_W-1:0];
                REG_REL_TIME: r_cfg.rel_time <= i_cfg.data[TIME_W-1:0];
                REG_CHAN_CNT: r_cfg.chan_cnt <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_smp.ready = in_ready;
    assign in_fire     = i_smp.valid && in_ready;
    assign cur_rec     = r_chan[r_scan_idx];

    uftq_chan_update u_update (
        .i_sample        (i_smp.sample),
        .i_cfg           (r_cfg),
        .i_rec           (cur_rec),
        .o_rec           (n_rec),
        .o_set_event     (set_ev),
        .o_release_event (rel_ev)
    );

    // Advance the scan. A count of zero wraps every beat, one above the depth is
    // capped by the depth itself, and a count lowered under the index wraps now.
    assign idx_next   = {1'b0, r_scan_idx} + NXT_W'(1);
    assign wrap       = (CMP_W'(idx_next) >= CMP_W'(r_cfg.chan_cnt))
                     || (idx_next == NXT_W'(MAX_CHANNELS));
    assign n_scan_idx = wrap ? '0 : idx_next[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_chan[i] <= '{st: ST_NORMAL, set_cnt: '0, rel_cnt: '0};
            end
        end else if (in_fire) begin
            r_scan_idx         <= n_scan_idx;
            r_chan[r_scan_idx] <= n_rec;
        end
    end

    // result beat
    assign ch_ext            = {{CH_W{1'b0}}, r_scan_idx};
    assign res.channel       = ch_ext[CH_W-1:0];
    assign res.set_event     = set_ev;
    assign res.release_event = rel_ev;
    assign res.fault_state   = n_rec.st;
    assign res.scan_done     = wrap;

    uftq_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in_res    (res),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_res   (out_res),
        .i_out_ready (o_res.ready)
    );

    assign o_res.valid         = out_valid;
    assign o_res.channel       = out_res.channel;
    assign o_res.set_event     = out_res.set_event;
    assign o_res.release_event = out_res.release_event;
    assign o_res.fault_state   = out_res.fault_state;
    assign o_res.scan_done     = out_res.scan_done;

endmodule

@@ design/uftq_checker.sv @@
// Port-level assertions for the fault qualifier, bound to the top level.
module uftq_checker import uftq_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic [CH_W-1:0] i_res_channel,
    input logic            i_res_set_event,
    input logic            i_res_release_event,
    input logic [1:0]      i_res_fault_state,
    input logic            i_res_scan_done
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_channel) && $stable(i_res_set_event)
            && $stable(i_res_release_event) && $stable(i_res_fault_state)
            && $stable(i_res_scan_done))
        else $error("result payload changed while stalled");

    // a set lands in set, or straight on in releasing, never with a release
    a_set_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_set_event |->
            !i_res_release_event
            && (i_res_fault_state == ST_SET || i_res_fault_state == ST_RELEASING))
        else $error("set event with wrong state");

    // a release always returns the channel to normal
    a_rel_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_release_event |-> i_res_fault_state == ST_NORMAL)
        else $error("release event without return to normal");

endmodule

bind multichannel_undertemp_fault_qualifier uftq_checker u_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_channel       (o_res.channel),
    .i_res_set_event     (o_res.set_event),
    .i_res_release_event (o_res.release_event),
    .i_res_fault_state   (o_res.fault_state),
    .i_res_scan_done     (o_res.scan_done)
);

@@ verif/tb_multichannel_undertemp_fault_qualifier.sv @@
// Self-checking testbench for the multichannel under-temperature fault qualifier.
`timescale 1ns / 1ps

module tb_multichannel_undertemp_fault_qualifier;
    import uftq_pkg::*;

    localparam int MAX_CH        = DEF_MAX_CHANNELS;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 3;
    localparam int PRINT_LIMIT   = 50;

    // Sample classes relative to the programmed thresholds.
    typedef enum {LVL_TRIP, LVL_CLEAR, LVL_EDGE, LVL_NOISE} t_level_kind;

    typedef struct {
        t_cfg_reg        idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    uftq_smp_if smp_ch ();
    uftq_res_if res_ch ();
    uftq_cfg_if cfg_ch ();

    multichannel_undertemp_fault_qualifier #(
        .MAX_CHANNELS (MAX_CH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and channel records.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  thr_set      = '0;
    logic [TIME_W-1:0] time_set     = '0;
    logic [THR_W-1:0]  thr_rel      = '0;
    logic [TIME_W-1:0] time_rel     = '0;
    logic [CNT_W-1:0]  scan_cnt_reg = CNT_W'(1);

    int unsigned       scan_pos = 0;
    t_fault_state      chan_st [MAX_CH] = '{default: ST_NORMAL};
    logic [TIME_W-1:0] set_run [MAX_CH] = '{default: '0};
    logic [TIME_W-1:0] rel_run [MAX_CH] = '{default: '0};

    // Pending traffic and the expected result of every accepted sample beat.
    logic [SAMPLE_W-1:0] sample_backlog [$];
    t_reg_write          reg_writes [$];
    t_result             pending_results [$];

    // Idle and stall odds, in percent, set per stage by the stimulus.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_done    = 0;
    int unsigned sets_seen      = 0;
    int unsigned releases_seen  = 0;
    int unsigned wraps_seen     = 0;
    int unsigned cycle_count    = 0;

    // Print one line per failure and count it; keep the log short on a broken build.
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d (result #%0d)",
                     $realtime, what, got, want, results_seen);
        end
        mismatch_count++;
    endtask

    // Apply one register write to the predictor's copy of the configuration.
    function automatic void apply_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SET_THR:  thr_set      = data[THR_W-1:0];
            REG_SET_TIME: time_set     = data[TIME_W-1:0];
            REG_REL_THR:  thr_rel      = data[THR_W-1:0];
            REG_REL_TIME: time_rel     = data[TIME_W-1:0];
            REG_CHAN_CNT: scan_cnt_reg = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Run one sample through the fault qualifier of the addressed channel,
    // advance the scan and return the result the block must produce.
    function automatic t_result qualify_sample(logic [SAMPLE_W-1:0] smp);
        t_result     res;
        int unsigned ch;
        int unsigned span;
        t_fault_state st;

        ch = (scan_pos < MAX_CH) ? scan_pos : 0;
        st = chan_st[ch];
        res.set_event     = 1'b0;
        res.release_event = 1'b0;

        // Set phase first: a cold sample strictly above the set threshold counts.
        if (smp > thr_set && time_set != 0) begin
            if (st == ST_NORMAL) begin
                st = ST_SETTING;
                set_run[ch] = TIME_W'(1);
            end else if (st == ST_SETTING) begin
                set_run[ch] = set_run[ch] + 1'b1;
                if (set_run[ch] >= time_set) begin
                    st = ST_SET;
                    set_run[ch] = '0;
                    res.set_event = 1'b1;
                end
            end
        end else if (st == ST_SETTING) begin
            st = ST_NORMAL;
        end

        // Release phase sees whatever the set phase left behind.
        if (smp < thr_rel && time_rel != 0) begin
            if (st == ST_SET) begin
                st = ST_RELEASING;
                rel_run[ch] = TIME_W'(1);
            end else if (st == ST_RELEASING) begin
                rel_run[ch] = rel_run[ch] + 1'b1;
                if (rel_run[ch] >= time_rel) begin
                    st = ST_NORMAL;
                    rel_run[ch] = '0;
                    res.release_event = 1'b1;
                end
            end
        end else if (st == ST_RELEASING) begin
            st = ST_SET;
        end

        chan_st[ch] = st;

        // Zero channels acts as one; anything past the array saturates.
        span = (scan_cnt_reg == 0) ? 1 : ((scan_cnt_reg > MAX_CH) ? MAX_CH : scan_cnt_reg);
        scan_pos = ch + 1;
        res.scan_done = 1'b0;
        if (scan_pos >= span) begin
            scan_pos = 0;
            res.scan_done = 1'b1;
        end

        res.channel     = CH_W'(ch);
        res.fault_state = st;
        return res;
    endfunction

    // Pick a sample of the requested class for the current thresholds.
    function automatic logic [SAMPLE_W-1:0] pick_sample(t_level_kind kind);
        case (kind)
            LVL_TRIP:  return (thr_set == '1) ? SAMPLE_W'($urandom)
                                              : SAMPLE_W'($urandom_range(16'hFFFF, thr_set + 1));
            LVL_CLEAR: return (thr_rel == '0) ? SAMPLE_W'($urandom)
                                              : SAMPLE_W'($urandom_range(thr_rel - 1, 0));
            LVL_EDGE:  return $urandom_range(1) ? thr_set : thr_rel;
            default:   return SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock and power-on values of every block input.
    // ------------------------------------------------------------------
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_SET_THR;
        cfg_ch.data   = '0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sample driver: predict on every accepted beat, then load the next one.
    // Hold valid and data while the block back-pressures.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                pending_results.push_back(qualify_sample(smp_ch.sample));
                samples_sent++;
            end
            if (!smp_ch.valid || smp_ch.ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    smp_ch.valid  <= 1'b1;
                    smp_ch.sample <= sample_backlog.pop_front();
                end else begin
                    smp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver: mirror each accepted write into the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reg_driver
        t_reg_write wr;
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(t_cfg_reg'(cfg_ch.index), cfg_ch.data);
                writes_done++;
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (reg_writes.size() != 0) begin
                    wr = reg_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= wr.idx;
                    cfg_ch.data  <= wr.data;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted beat with the oldest expectation,
    // and stall the output at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", res_ch.channel, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.channel !== want.channel)
                        report_mismatch("channel", res_ch.channel, want.channel);
                    if (res_ch.set_event !== want.set_event)
                        report_mismatch("set_event", res_ch.set_event, want.set_event);
                    if (res_ch.release_event !== want.release_event)
                        report_mismatch("release_event", res_ch.release_event,
                                        want.release_event);
                    if (res_ch.fault_state !== want.fault_state)
                        report_mismatch("fault_state", res_ch.fault_state, want.fault_state);
                    if (res_ch.scan_done !== want.scan_done)
                        report_mismatch("scan_done", res_ch.scan_done, want.scan_done);
                    sets_seen     += want.set_event;
                    releases_seen += want.release_event;
                    wraps_seen    += want.scan_done;
                end
                results_seen++;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop in case the block hangs on a handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding, %0d samples unsent",
                     cycle_count, pending_results.size(), sample_backlog.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Wait until every beat has gone out and every result has come back,
    // then let the pipeline settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || smp_ch.valid || pending_results.size() != 0
               || reg_writes.size() != 0 || cfg_ch.valid);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Program all five registers while the block is idle.
    task automatic configure(logic [15:0] s_thr, logic [7:0] s_time,
                             logic [15:0] r_thr, logic [7:0] r_time, logic [5:0] n_ch);
        wait_idle();
        reg_writes.push_back('{REG_SET_THR,  s_thr});
        reg_writes.push_back('{REG_SET_TIME, CFG_DATA_W'(s_time)});
        reg_writes.push_back('{REG_REL_THR,  r_thr});
        reg_writes.push_back('{REG_REL_TIME, CFG_DATA_W'(r_time)});
        reg_writes.push_back('{REG_CHAN_CNT, CFG_DATA_W'(n_ch)});
        wait_idle();
    endtask

    // One random setting followed by runs of trip and clear samples, each at most long
    // enough to walk every channel through set and release, with breaks and noise mixed in.
    task automatic random_phase(int n_items, bit pause_midway);
        logic [15:0] s_thr, r_thr;
        logic [7:0]  s_time, r_time;
        logic [5:0]  n_ch;
        int          span, seg_max, seg, left, pick;
        t_level_kind kind;

        case ($urandom_range(5))
            0: begin
                s_thr = 16'($urandom);
                r_thr = 16'($urandom);
            end
            1: begin
                // overlapping thresholds: one sample can trip and clear at once
                s_thr = 16'($urandom_range(16'h7FFF, 0));
                r_thr = 16'($urandom_range(16'hFFFF, s_thr + 2));
            end
            default: begin
                s_thr = 16'($urandom_range(16'hFFFE, 16'h4000));
                r_thr = 16'($urandom_range(s_thr, 1));
            end
        endcase
        s_time = ($urandom_range(9) == 0) ? 8'd0 :
                 ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5, 1));
        r_time = ($urandom_range(9) == 0) ? 8'd0 :
                 ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5, 1));
        n_ch   = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4, 1));
        configure(s_thr, s_time, r_thr, r_time, n_ch);

        span    = (n_ch == 0) ? 1 : ((n_ch > MAX_CH) ? MAX_CH : n_ch);
        seg_max = ((s_time > r_time ? s_time : r_time) + 2) * span;
        left    = n_items;
        while (left > 0) begin
            pick = $urandom_range(9);
            kind = (pick < 4) ? LVL_TRIP : (pick < 8) ? LVL_CLEAR :
                   (pick == 8) ? LVL_EDGE : LVL_NOISE;
            seg = $urandom_range(seg_max, 1);
            if (seg > left)
                seg = left;
            repeat (seg) begin
                sample_backlog.push_back(pick_sample(kind));
                left--;
                // hold the sender until the block has fully drained
                if (pause_midway && left == n_items / 2)
                    wait_idle();
            end
        end
    endtask

    // Run a stage of random phases under one idling pattern.
    task automatic run_stage(int unsigned send_pct, int unsigned stall_pct,
                             int n_phases, int items_each);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int p = 0; p < n_phases; p++)
            random_phase(items_each, p == 0);
    endtask

    initial begin
        // walk one channel through every transition, thresholds hit exactly
        static logic [15:0] walk [10] = '{16'hFFFF, 16'h8000, 16'h8001, 16'hFFFF, 16'h8000,
                                          16'h1000, 16'h0FFF, 16'h5000, 16'h0000, 16'h0000};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part runs with the first idling pattern.
        send_idle_pct  = 17;
        recv_stall_pct = 81;

        // Reset settings: both phases disabled, nothing may change.
        sample_backlog.push_back(16'h0000);
        sample_backlog.push_back(16'hFFFF);

        // Single channel, time of one: set and release each take two samples;
        // equal-to-threshold samples break a run.
        configure(16'h8000, 8'd1, 16'h1000, 8'd1, 6'd1);
        foreach (walk[i])
            sample_backlog.push_back(walk[i]);

        // Zero channels acts as one: every beat wraps.
        configure(16'h8000, 8'd1, 16'h1000, 8'd1, 6'd0);
        sample_backlog.push_back(16'hFFFF);
        sample_backlog.push_back(16'h0000);

        // Overlapping thresholds over three channels, then shrink the scan below
        // the current index: channel two is still served before the wrap.
        configure(16'h0000, 8'd1, 16'hFFFF, 8'd1, 6'd3);
        sample_backlog.push_back(16'h7FFF);
        sample_backlog.push_back(16'h7FFF);
        configure(16'h0000, 8'd1, 16'hFFFF, 8'd1, 6'd1);
        repeat (3)
            sample_backlog.push_back(16'h7FFF);

        // Extreme settings: top set threshold, zero release threshold, longest
        // times, channel count past the array.
        configure(16'hFFFF, 8'd255, 16'h0000, 8'd255, 6'd63);
        sample_backlog.push_back(16'hFFFF);
        sample_backlog.push_back(16'h0000);

        // Random part: receiver-limited, then sender-limited.
        run_stage(17, 81, 4, 65);
        run_stage(81, 17, 4, 65);

        // No idling: run the counters all the way to 255 on one channel.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(16'h8000, 8'd255, 16'h2000, 8'd255, 6'd1);
        repeat (256)
            sample_backlog.push_back(pick_sample(LVL_TRIP));
        repeat (256)
            sample_backlog.push_back(pick_sample(LVL_CLEAR));
        random_phase(40, 1'b0);
        random_phase(40, 1'b0);

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("Run covered %0d sample beats, %0d results, %0d register writes",
                 samples_sent, results_seen, writes_done);
        $display("Fault activity: %0d sets, %0d releases, %0d scan wraps, %0d mismatches",
                 sets_seen, releases_seen, wraps_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ multichannel_undertemp_fault_qualifier.f @@
design/uftq_pkg.sv
design/uftq_if.sv
design/uftq_chan_update.sv
design/uftq_out_skid.sv
design/multichannel_undertemp_fault_qualifier.sv
design/uftq_checker.sv
verif/tb_multichannel_undertemp_fault_qualifier.sv
